// ===== rtl/i2p_pkg.sv =====
package i2p_pkg;

  // Operator codes as held on the stack. Close and operand are classes only.
  typedef enum logic [2:0] {
    OP_OPEN    = 3'd0,
    OP_PLUS    = 3'd1,
    OP_MINUS   = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_POW     = 3'd5,
    OP_CLOSE   = 3'd6,
    OP_OPERAND = 3'd7
  } op_code_t;

  typedef enum logic [1:0] {
    KIND_OPERAND  = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_END      = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_OPERAND_LONG = 2'd1,
    ERR_OVERFLOW     = 2'd2,
    ERR_UNBALANCED   = 2'd3
  } error_t;

  // ASCII codes of the symbol characters.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic       token_end;
    logic       last_of_run;
    error_t     error;
  } token_item_t;

  // Maps an input character to its operator code or class.
  function automatic op_code_t classify(input logic [7:0] c);
    op_code_t code;
    case (c)
      CH_OPEN:  code = OP_OPEN;
      CH_PLUS:  code = OP_PLUS;
      CH_MINUS: code = OP_MINUS;
      CH_MUL:   code = OP_MUL;
      CH_DIV:   code = OP_DIV;
      CH_POW:   code = OP_POW;
      CH_CLOSE: code = OP_CLOSE;
      default:  code = OP_OPERAND;
    endcase
    return code;
  endfunction

  // True when the stacked operator leaves the stack before the incoming one is pushed.
  function automatic logic pops_before(input op_code_t stacked, input op_code_t incoming);
    logic result;
    if (stacked == OP_OPEN) begin
      result = 1'b0;
    end else if (stacked == incoming) begin
      result = 1'b1;
    end else if (incoming == OP_PLUS || incoming == OP_MINUS) begin
      result = 1'b1;
    end else if ((incoming == OP_MUL || incoming == OP_DIV) &&
                 (stacked == OP_MUL || stacked == OP_DIV || stacked == OP_POW)) begin
      result = 1'b1;
    end else begin
      result = 1'b0;
    end
    return result;
  endfunction

  // Character sent out for a stacked operator code.
  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] c;
    case (code)
      OP_OPEN:  c = CH_OPEN;
      OP_PLUS:  c = CH_PLUS;
      OP_MINUS: c = CH_MINUS;
      OP_MUL:   c = CH_MUL;
      OP_DIV:   c = CH_DIV;
      OP_POW:   c = CH_POW;
      default:  c = CH_OPEN;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/i2p_chan_if.sv =====
interface i2p_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2p_ram.sv =====
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/infix_to_postfix_converter_core.sv =====
// Infix to postfix converter: takes one character per transfer on chars and sends the
// postfix form on tokens, one character per transfer, with an end marker after the last
// character of each expression carrying the error code (operand too long, operator stack
// overflow, unbalanced close); after an error the rest of the expression is dropped. An
// operand character that is not the last of its expression is only buffered. A close or
// an operator first sends any buffered operand characters (one operand buffer read each),
// then reads the stack top and pops operators (one stack memory read each), and for an
// operator ends with its push; an open parenthesis skips the stack reads and is pushed.
// The last item then closes the expression, popping operators as a close does, and sends
// the end marker. An item that arrives after an error is dropped, but a last item still
// sends the end marker. A stall on tokens holds the block. The operator stack and operand
// buffer memories need no clearing after reset.
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH       = 32,
  parameter int MAX_OPERAND_CHARS = 8
) (
  input logic       clk,
  input logic       rst,
  i2p_chan_if.sink   chars,
  i2p_chan_if.source tokens
);

  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int BUF_AW = (MAX_OPERAND_CHARS > 1) ? $clog2(MAX_OPERAND_CHARS) : 1;
  localparam int LEN_W  = $clog2(MAX_OPERAND_CHARS + 1);
  localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [LEN_W-1:0] BUF_FULL   = LEN_W'(MAX_OPERAND_CHARS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FL_RD,
    S_FL_OUT,
    S_POP_RD,
    S_POP_CHK,
    S_PUSH,
    S_DONE,
    S_END,
    S_FIN
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [LEN_W-1:0]      oplen;
  logic [LEN_W-1:0]      fl_idx;
  logic                  in_expr;
  i2p_pkg::error_t       err;
  i2p_pkg::op_code_t     cur_cls;
  logic                  from_input;
  logic                  last_item;
  logic                  pend_valid;
  i2p_pkg::token_item_t  pend;
  logic                  out_valid;
  i2p_pkg::token_item_t  out_data;

  i2p_pkg::char_item_t   in_data;
  i2p_pkg::op_code_t     in_cls;
  logic                  accept;
  i2p_pkg::error_t       eff_err;
  logic [LEN_W-1:0]      eff_len;
  logic [LEN_W-1:0]      fl_next;
  logic [CNT_W-1:0]      cnt_m1;
  logic [CNT_W-1:0]      cnt_m2;
  i2p_pkg::op_code_t     top;
  logic                  slot_free;
  logic                  can_emit;
  logic                  emit_req;
  i2p_pkg::token_item_t  emit_item;
  logic                  pop_go;
  logic                  out_load;
  i2p_pkg::token_item_t  load_item;

  logic                  buf_we;
  logic [BUF_AW-1:0]     buf_waddr;
  logic                  buf_re;
  logic [BUF_AW-1:0]     buf_raddr;
  logic [7:0]            buf_rdata;
  logic                  stk_we;
  logic [SP_W-1:0]       stk_waddr;
  logic [2:0]            stk_wdata;
  logic                  stk_re;
  logic [SP_W-1:0]       stk_raddr;
  logic [2:0]            stk_rdata;

  // Handshakes and decoded input.
  assign chars.ready  = (state == S_IDLE);
  assign accept       = chars.valid && chars.ready;
  assign in_data      = chars.data;
  assign in_cls       = i2p_pkg::classify(in_data.ch);
  assign tokens.valid = out_valid;
  assign tokens.data  = out_data;

  // A new expression starts from a clean state.
  assign eff_err = in_expr ? err : i2p_pkg::ERR_NONE;
  assign eff_len = in_expr ? oplen : '0;

  assign fl_next = fl_idx + 1'b1;
  assign cnt_m1  = count - 1'b1;
  assign cnt_m2  = count - CNT_W'(2);
  assign top     = i2p_pkg::op_code_t'(stk_rdata);

  // A new result goes to the pending slot; the one there moves to the output register.
  assign slot_free = !out_valid || tokens.ready;
  assign can_emit  = !pend_valid || slot_free;

  // Result requested in the current state.
  always_comb begin
    emit_req  = 1'b0;
    emit_item = '{kind: i2p_pkg::KIND_OPERAND, out_char: buf_rdata,
                  token_end: (fl_next == oplen), last_of_run: 1'b0,
                  error: i2p_pkg::ERR_NONE};
    case (state)
      S_FL_OUT: begin
        emit_req = 1'b1;
      end
      S_POP_CHK: begin
        emit_req = (count != '0) && (top != i2p_pkg::OP_OPEN) &&
                   (cur_cls == i2p_pkg::OP_CLOSE || i2p_pkg::pops_before(top, cur_cls));
        emit_item.kind      = i2p_pkg::KIND_OPERATOR;
        emit_item.out_char  = i2p_pkg::op_char(top);
        emit_item.token_end = 1'b1;
      end
      S_END: begin
        emit_req = 1'b1;
        emit_item.kind      = i2p_pkg::KIND_END;
        emit_item.out_char  = '0;
        emit_item.token_end = 1'b1;
        emit_item.error     = err;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign pop_go = (state == S_POP_CHK) && emit_req && can_emit;

  // The pending result moves out when a newer one arrives or when the run finishes;
  // the final result of a run leaves with last_of_run set.
  assign out_load = pend_valid && ((emit_req && can_emit) || ((state == S_FIN) && slot_free));

  always_comb begin
    load_item             = pend;
    load_item.last_of_run = (state == S_FIN);
  end

  // Operand buffer access: written on accept, read during the flush.
  assign buf_we    = accept && (eff_err == i2p_pkg::ERR_NONE) &&
                     (in_cls == i2p_pkg::OP_OPERAND) && (eff_len < BUF_FULL);
  assign buf_waddr = eff_len[BUF_AW-1:0];
  assign buf_re    = (state == S_FL_RD) ||
                     ((state == S_FL_OUT) && can_emit && (fl_next != oplen));
  assign buf_raddr = (state == S_FL_OUT) ? fl_next[BUF_AW-1:0] : fl_idx[BUF_AW-1:0];

  // Stack access: the outer open parenthesis at the start, pushes, and top reads.
  // A pop reads the entry below at once, so pops run one per cycle while tokens do not stall.
  assign stk_we    = (accept && !in_expr) || ((state == S_PUSH) && (count < STACK_FULL));
  assign stk_waddr = (state == S_PUSH) ? count[SP_W-1:0] : '0;
  assign stk_wdata = (state == S_PUSH) ? cur_cls : i2p_pkg::OP_OPEN;
  assign stk_re    = (state == S_POP_RD) || pop_go;
  assign stk_raddr = (state == S_POP_RD) ? cnt_m1[SP_W-1:0] : cnt_m2[SP_W-1:0];

  i2p_ram #(
    .WIDTH (8),
    .DEPTH (MAX_OPERAND_CHARS),
    .AW    (BUF_AW)
  ) u_operand_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (in_data.ch),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  i2p_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH),
    .AW    (SP_W)
  ) u_op_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Sequencer, result staging and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      oplen      <= '0;
      in_expr    <= 1'b0;
      err        <= i2p_pkg::ERR_NONE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= load_item;
      end else if (out_valid && tokens.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_req && can_emit) begin
        pend       <= emit_item;
        pend_valid <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            in_expr    <= 1'b1;
            last_item  <= in_data.last_char;
            // A final operand character leads straight to the closing of the expression.
            cur_cls    <= (in_cls == i2p_pkg::OP_OPERAND) ? i2p_pkg::OP_CLOSE : in_cls;
            from_input <= (in_cls != i2p_pkg::OP_OPERAND);
            fl_idx     <= '0;
            if (!in_expr) begin
              count <= CNT_W'(1);
              err   <= i2p_pkg::ERR_NONE;
            end
            if (eff_err != i2p_pkg::ERR_NONE) begin
              state <= in_data.last_char ? S_END : S_IDLE;
            end else if (in_cls == i2p_pkg::OP_OPERAND) begin
              if (eff_len >= BUF_FULL) begin
                err   <= i2p_pkg::ERR_OPERAND_LONG;
                state <= in_data.last_char ? S_END : S_IDLE;
              end else begin
                oplen <= eff_len + 1'b1;
                // The final operand character closes the expression right away.
                if (in_data.last_char) begin
                  state <= S_FL_RD;
                end
              end
            end else if (eff_len != '0) begin
              state <= S_FL_RD;
            end else if (in_cls == i2p_pkg::OP_OPEN) begin
              state <= S_PUSH;
            end else begin
              state <= S_POP_RD;
            end
          end
        end

        S_FL_RD: begin
          state <= S_FL_OUT;
        end

        S_FL_OUT: begin
          if (can_emit) begin
            if (fl_next == oplen) begin
              oplen <= '0;
              state <= (cur_cls == i2p_pkg::OP_OPEN) ? S_PUSH : S_POP_RD;
            end else begin
              fl_idx <= fl_next;
            end
          end
        end

        S_POP_RD: begin
          state <= S_POP_CHK;
        end

        S_POP_CHK: begin
          if (count == '0) begin
            if (cur_cls == i2p_pkg::OP_CLOSE) begin
              err   <= i2p_pkg::ERR_UNBALANCED;
              state <= S_DONE;
            end else begin
              state <= S_PUSH;
            end
          end else if (top == i2p_pkg::OP_OPEN && cur_cls == i2p_pkg::OP_CLOSE) begin
            // A close from the input must not remove the outer parenthesis.
            count <= cnt_m1;
            if (from_input && cnt_m1 == '0) begin
              err <= i2p_pkg::ERR_UNBALANCED;
            end
            state <= S_DONE;
          end else if (emit_req) begin
            if (can_emit) begin
              count <= cnt_m1;
            end
          end else begin
            state <= S_PUSH;
          end
        end

        S_PUSH: begin
          if (count < STACK_FULL) begin
            count <= count + 1'b1;
          end else begin
            err <= i2p_pkg::ERR_OVERFLOW;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (err != i2p_pkg::ERR_NONE) begin
            state <= last_item ? S_END : S_FIN;
          end else if (from_input && last_item) begin
            // The operand buffer is empty after a symbol, so the close goes to the stack.
            cur_cls    <= i2p_pkg::OP_CLOSE;
            from_input <= 1'b0;
            state      <= S_POP_RD;
          end else begin
            state <= last_item ? S_END : S_FIN;
          end
        end

        S_END: begin
          if (can_emit) begin
            in_expr <= 1'b0;
            err     <= i2p_pkg::ERR_NONE;
            count   <= '0;
            oplen   <= '0;
            state   <= S_FIN;
          end
        end

        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/i2p_checker.sv =====
module i2p_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2p_pkg::token_item_t out_data,
  input logic                 in_ready
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The end marker always closes the run of results.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == i2p_pkg::KIND_END |->
      out_data.last_of_run && out_data.token_end)
    else $error("end marker not marked as last");

  // Error codes appear only on end markers.
  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error != i2p_pkg::ERR_NONE |-> out_data.kind == i2p_pkg::KIND_END)
    else $error("error code on a non end result");

  // Operators are single-character tokens.
  a_op_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == i2p_pkg::KIND_OPERATOR |-> out_data.token_end)
    else $error("operator without token end");

  // No new character is taken while the current run is still unfinished.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("input ready in the middle of a run");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tokens.valid),
  .out_ready (tokens.ready),
  .out_data  (tokens.data),
  .in_ready  (chars.ready)
);

// ===== tb/i2p_token_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts the postfix token stream from each accepted
// character and compares every accepted token against the oldest prediction.
module i2p_token_checker #(
  parameter int STACK_DEPTH       = 32,
  parameter int MAX_OPERAND_CHARS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 chars_valid,
  input  logic                 chars_ready,
  input  i2p_pkg::char_item_t  chars_data,
  input  logic                 tokens_valid,
  input  logic                 tokens_ready,
  input  i2p_pkg::token_item_t tokens_data,
  output int                   mismatches,
  output int                   pending,
  output int                   compared
);

  // Predictor state.
  i2p_pkg::op_code_t    op_stack [STACK_DEPTH];
  int                   stack_fill;
  logic [7:0]           operand_buf [MAX_OPERAND_CHARS];
  int                   operand_fill;
  bit                   in_expr;
  i2p_pkg::error_t      latched_err;
  i2p_pkg::token_item_t expected_tokens [$];

  // Prints one line per mismatch (the first 40) and counts all of them.
  task automatic report_mismatch(string msg);
    if (mismatches < 40) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic i2p_pkg::op_code_t char_to_code(logic [7:0] c);
    case (c)
      i2p_pkg::CH_OPEN:  return i2p_pkg::OP_OPEN;
      i2p_pkg::CH_CLOSE: return i2p_pkg::OP_CLOSE;
      i2p_pkg::CH_PLUS:  return i2p_pkg::OP_PLUS;
      i2p_pkg::CH_MINUS: return i2p_pkg::OP_MINUS;
      i2p_pkg::CH_MUL:   return i2p_pkg::OP_MUL;
      i2p_pkg::CH_DIV:   return i2p_pkg::OP_DIV;
      i2p_pkg::CH_POW:   return i2p_pkg::OP_POW;
      default:           return i2p_pkg::OP_OPERAND;
    endcase
  endfunction

  function automatic logic [7:0] code_to_char(i2p_pkg::op_code_t code);
    case (code)
      i2p_pkg::OP_PLUS:  return i2p_pkg::CH_PLUS;
      i2p_pkg::OP_MINUS: return i2p_pkg::CH_MINUS;
      i2p_pkg::OP_MUL:   return i2p_pkg::CH_MUL;
      i2p_pkg::OP_DIV:   return i2p_pkg::CH_DIV;
      i2p_pkg::OP_POW:   return i2p_pkg::CH_POW;
      default:           return i2p_pkg::CH_OPEN;
    endcase
  endfunction

  // Precedence: the stacked operator leaves first on equal operators, on any
  // incoming + or -, and on an incoming * or / over a stacked *, / or ^.
  function automatic bit leaves_first(i2p_pkg::op_code_t stacked,
                                      i2p_pkg::op_code_t incoming);
    if (stacked == i2p_pkg::OP_OPEN) begin
      return 1'b0;
    end
    if (stacked == incoming || incoming == i2p_pkg::OP_PLUS ||
        incoming == i2p_pkg::OP_MINUS) begin
      return 1'b1;
    end
    return (incoming == i2p_pkg::OP_MUL || incoming == i2p_pkg::OP_DIV) &&
           (stacked == i2p_pkg::OP_MUL || stacked == i2p_pkg::OP_DIV ||
            stacked == i2p_pkg::OP_POW);
  endfunction

  task automatic push_token(i2p_pkg::kind_t k, logic [7:0] c, logic tend,
                            i2p_pkg::error_t e);
    i2p_pkg::token_item_t t;
    t.kind        = k;
    t.out_char    = c;
    t.token_end   = tend;
    t.last_of_run = 1'b0;
    t.error       = e;
    expected_tokens.push_back(t);
  endtask

  // Handles one character, explicit or the implicit closing parenthesis.
  task automatic convert_char(logic [7:0] c, bit explicit_char);
    i2p_pkg::op_code_t code;
    i2p_pkg::op_code_t top_code;
    int                i;
    code = char_to_code(c);
    // Operand characters are only buffered.
    if (code == i2p_pkg::OP_OPERAND) begin
      if (operand_fill >= MAX_OPERAND_CHARS) begin
        latched_err = i2p_pkg::ERR_OPERAND_LONG;
      end else begin
        operand_buf[operand_fill] = c;
        operand_fill++;
      end
      return;
    end
    // Any symbol flushes the buffered operand as one token.
    for (i = 0; i < operand_fill; i++) begin
      push_token(i2p_pkg::KIND_OPERAND, operand_buf[i], i == operand_fill - 1,
                 i2p_pkg::ERR_NONE);
    end
    operand_fill = 0;
    // A close pops operators until the matching open.
    if (code == i2p_pkg::OP_CLOSE) begin
      forever begin
        if (stack_fill == 0) begin
          latched_err = i2p_pkg::ERR_UNBALANCED;
          return;
        end
        stack_fill--;
        top_code = op_stack[stack_fill];
        if (top_code == i2p_pkg::OP_OPEN) begin
          if (explicit_char && stack_fill == 0) begin
            latched_err = i2p_pkg::ERR_UNBALANCED;
          end
          return;
        end
        push_token(i2p_pkg::KIND_OPERATOR, code_to_char(top_code), 1'b1,
                   i2p_pkg::ERR_NONE);
      end
    end
    // Operators pop by precedence, then everything but a close is pushed.
    if (code != i2p_pkg::OP_OPEN) begin
      while (stack_fill > 0 && leaves_first(op_stack[stack_fill - 1], code)) begin
        stack_fill--;
        push_token(i2p_pkg::KIND_OPERATOR, code_to_char(op_stack[stack_fill]), 1'b1,
                   i2p_pkg::ERR_NONE);
      end
    end
    if (stack_fill >= STACK_DEPTH) begin
      latched_err = i2p_pkg::ERR_OVERFLOW;
    end else begin
      op_stack[stack_fill] = code;
      stack_fill++;
    end
  endtask

  // Works out every token that one accepted character causes.
  task automatic predict_tokens(i2p_pkg::char_item_t item);
    int                   first;
    i2p_pkg::token_item_t t;
    first = expected_tokens.size();
    if (!in_expr) begin
      operand_fill = 0;
      latched_err  = i2p_pkg::ERR_NONE;
      op_stack[0]  = i2p_pkg::OP_OPEN;
      stack_fill   = 1;
      in_expr      = 1'b1;
    end
    if (latched_err == i2p_pkg::ERR_NONE) begin
      convert_char(item.ch, 1'b1);
      if (item.last_char && latched_err == i2p_pkg::ERR_NONE) begin
        convert_char(i2p_pkg::CH_CLOSE, 1'b0);
      end
    end
    if (item.last_char) begin
      push_token(i2p_pkg::KIND_END, 8'h00, 1'b1, latched_err);
      in_expr      = 1'b0;
      latched_err  = i2p_pkg::ERR_NONE;
      stack_fill   = 0;
      operand_fill = 0;
    end
    // Mark the final token of this run.
    if (expected_tokens.size() > first) begin
      t = expected_tokens.pop_back();
      t.last_of_run = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  // Compares one accepted token field by field with the oldest prediction.
  task automatic check_token(i2p_pkg::token_item_t got);
    i2p_pkg::token_item_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token kind=%0d char=%02h", got.kind,
                                got.out_char));
      return;
    end
    want = expected_tokens.pop_front();
    compared++;
    if (got.kind !== want.kind) begin
      report_mismatch($sformatf("token %0d kind %0d, expected %0d", compared, got.kind,
                                want.kind));
    end
    if (got.out_char !== want.out_char) begin
      report_mismatch($sformatf("token %0d char %02h, expected %02h", compared,
                                got.out_char, want.out_char));
    end
    if (got.token_end !== want.token_end) begin
      report_mismatch($sformatf("token %0d token_end %b, expected %b", compared,
                                got.token_end, want.token_end));
    end
    if (got.last_of_run !== want.last_of_run) begin
      report_mismatch($sformatf("token %0d last_of_run %b, expected %b", compared,
                                got.last_of_run, want.last_of_run));
    end
    if (got.error !== want.error) begin
      report_mismatch($sformatf("token %0d error %0d, expected %0d", compared, got.error,
                                want.error));
    end
  endtask

  // Monitor both channels on every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_expr      = 1'b0;
      latched_err  = i2p_pkg::ERR_NONE;
      stack_fill   = 0;
      operand_fill = 0;
      expected_tokens.delete();
    end else begin
      if (tokens_valid && tokens_ready) begin
        check_token(tokens_data);
      end
      if (chars_valid && chars_ready) begin
        predict_tokens(chars_data);
      end
    end
    pending <= expected_tokens.size();
  end

endmodule

// ===== tb/tb_infix_to_postfix_converter_core.sv =====
`timescale 1ns / 100ps

module tb_infix_to_postfix_converter_core;

  localparam int RANDOM_CHARS = 140;

  logic clk = 1'b0;
  logic rst;

  i2p_chan_if #(.T(i2p_pkg::char_item_t))  chars_if ();
  i2p_chan_if #(.T(i2p_pkg::token_item_t)) tokens_if ();

  int         mismatches;
  int         pending;
  int         compared;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         chars_sent;
  int         exprs_sent;
  logic [7:0] expr_text [$];

  infix_to_postfix_converter_core u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  i2p_token_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .chars_valid  (chars_if.valid),
    .chars_ready  (chars_if.ready),
    .chars_data   (chars_if.data),
    .tokens_valid (tokens_if.valid),
    .tokens_ready (tokens_if.ready),
    .tokens_data  (tokens_if.data),
    .mismatches   (mismatches),
    .pending      (pending),
    .compared     (compared)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      tokens_if.ready <= 1'b0;
    end else begin
      tokens_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard limit on the run.
  initial begin
    #8_000_000;
    $display("Timeout with %0d tokens still expected", pending);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit is_symbol(logic [7:0] c);
    return c == i2p_pkg::CH_OPEN || c == i2p_pkg::CH_CLOSE || c == i2p_pkg::CH_PLUS ||
           c == i2p_pkg::CH_MINUS || c == i2p_pkg::CH_MUL || c == i2p_pkg::CH_DIV ||
           c == i2p_pkg::CH_POW;
  endfunction

  function automatic logic [7:0] rand_operand_char();
    logic [7:0] c;
    do begin
      c = $urandom_range(255);
    end while (is_symbol(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(4))
      0:       return i2p_pkg::CH_PLUS;
      1:       return i2p_pkg::CH_MINUS;
      2:       return i2p_pkg::CH_MUL;
      3:       return i2p_pkg::CH_DIV;
      default: return i2p_pkg::CH_POW;
    endcase
  endfunction

  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(6))
      0:       return i2p_pkg::CH_OPEN;
      1:       return i2p_pkg::CH_CLOSE;
      default: return rand_operator();
    endcase
  endfunction

  task automatic add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      expr_text.push_back(s[i]);
    end
  endtask

  task automatic add_operand(int len);
    repeat (len) expr_text.push_back(rand_operand_char());
  endtask

  // Random well-formed expression with nested parentheses.
  task automatic build_wellformed();
    int terms;
    int depth;
    int k;
    terms = $urandom_range(1, 6);
    depth = 0;
    for (k = 0; k < terms; k++) begin
      while ($urandom_range(3) == 0) begin
        expr_text.push_back(i2p_pkg::CH_OPEN);
        depth++;
      end
      add_operand($urandom_range(1, ($urandom_range(4) == 0) ? 8 : 3));
      while (depth > 0 && $urandom_range(2) == 0) begin
        expr_text.push_back(i2p_pkg::CH_CLOSE);
        depth--;
      end
      if (k != terms - 1) begin
        expr_text.push_back(rand_operator());
      end
    end
    while (depth > 0) begin
      expr_text.push_back(i2p_pkg::CH_CLOSE);
      depth--;
    end
  endtask

  // Nesting deep enough to reach the stack limit, on either side of it.
  task automatic build_deep();
    int n;
    if ($urandom_range(1)) begin
      n = $urandom_range(29, 33);
      repeat (n) expr_text.push_back(i2p_pkg::CH_OPEN);
      add_operand(1);
    end else begin
      n = $urandom_range(14, 17);
      repeat (n) begin
        add_operand(1);
        expr_text.push_back(rand_operator());
        expr_text.push_back(i2p_pkg::CH_OPEN);
      end
      add_operand(1);
    end
    repeat ($urandom_range(0, n)) expr_text.push_back(i2p_pkg::CH_CLOSE);
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(1)) begin
        expr_text.push_back(rand_symbol());
      end else begin
        expr_text.push_back(rand_operand_char());
      end
    end
  endtask

  // Offers one character, with idle cycles before it at the phase's rate.
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.data  <= '{ch: c, last_char: last};
    do begin
      @(posedge clk);
    end while (!chars_if.ready);
    chars_sent++;
  endtask

  // Sends the built expression with the final character marked, then clears it.
  task automatic send_expr();
    int i;
    for (i = 0; i < expr_text.size(); i++) begin
      send_char(expr_text[i], i == expr_text.size() - 1);
    end
    expr_text.delete();
    exprs_sent++;
  endtask

  initial begin
    int start;
    int r;
    int phase;
    rst            <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.data  <= '0;
    send_idle_pct  = 29;
    recv_idle_pct  = 87;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Extreme operand codes, every operator, an explicit group and a ^ chain.
    expr_text.push_back(8'h00);
    expr_text.push_back(i2p_pkg::CH_PLUS);
    expr_text.push_back(i2p_pkg::CH_OPEN);
    expr_text.push_back(8'hFF);
    expr_text.push_back(i2p_pkg::CH_MINUS);
    add_text("b");
    expr_text.push_back(i2p_pkg::CH_CLOSE);
    expr_text.push_back(i2p_pkg::CH_MUL);
    add_text("c");
    expr_text.push_back(i2p_pkg::CH_POW);
    add_text("d");
    expr_text.push_back(i2p_pkg::CH_POW);
    add_text("e");
    expr_text.push_back(i2p_pkg::CH_DIV);
    add_text("f");
    send_expr();
    // Operand one character over the buffer size.
    add_text("abcdefghi");
    send_expr();
    // A close with nothing open.
    expr_text.push_back(i2p_pkg::CH_CLOSE);
    send_expr();
    // An open left unclosed, with an operator below it.
    add_text("a");
    expr_text.push_back(i2p_pkg::CH_PLUS);
    expr_text.push_back(i2p_pkg::CH_OPEN);
    add_text("b");
    send_expr();

    // Random expressions through three stall mixes.
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      phase = (chars_sent - start) * 3 / RANDOM_CHARS;
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 29 : 0;
      r = $urandom_range(99);
      if (exprs_sent % 9 == 4) begin
        build_deep();
      end else if (r < 58) begin
        build_wellformed();
      end else if (r < 70) begin
        // Broken parenthesization around a well-formed body.
        if ($urandom_range(1)) begin
          expr_text.push_back(i2p_pkg::CH_OPEN);
        end
        build_wellformed();
        if ($urandom_range(1)) begin
          expr_text.push_back(i2p_pkg::CH_CLOSE);
        end
      end else if (r < 78) begin
        add_operand($urandom_range(8, 10));
        if ($urandom_range(1)) begin
          expr_text.push_back(rand_operator());
          add_operand(1);
        end
      end else begin
        build_noise();
      end
      send_expr();
    end
    chars_if.valid <= 1'b0;

    // Drain the outstanding tokens, then watch for stray ones.
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);

    $display("Sent %0d expressions (%0d characters); compared %0d output tokens.",
             exprs_sent, chars_sent, compared);
    $display("Stall mixes: sender 29%%/receiver 87%%, then 87%%/29%%, then none.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
